// File: design/sasl_pkg.sv
// Package for the servo angle slew limiter.
// Holds register codes, shared types and the degree-to-offset mapping.
// No dependencies.
package sasl_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_TRIM     = 2'd0;
    localparam logic [1:0] REG_STEP     = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam logic [8:0]  STEP_RESET     = 9'd10;
    localparam logic [9:0]  INTERVAL_RESET = 10'd10;
    localparam logic [9:0]  CNT_MAX        = 10'd1023;

    localparam logic signed [12:0] PULSE_CENTER = 13'sd1500;
    localparam logic signed [12:0] PULSE_MIN    = 13'sd500;
    localparam logic signed [12:0] PULSE_MAX    = 13'sd2500;

    typedef struct packed {
        logic [8:0]        step_size;
        logic [9:0]        interval;
        logic signed [9:0] trim_off;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic signed [9:0] angle_off;
    } t_item;

    // (x+90)*1000/180-500 with x in -90..90; /9 done by reciprocal 7282/2^16
    function automatic logic signed [9:0] deg_to_off(input logic signed [7:0] x);
        logic signed [8:0]  s;
        logic [7:0]         u;
        logic [13:0]        v;
        logic [26:0]        p;
        logic signed [11:0] q;
        s = 9'(x) + 9'sd90;
        u = s[7:0];
        v = 14'(u) * 14'd50;
        p = 27'(v) * 27'd7282;
        q = $signed({1'b0, p[26:16]}) - 12'sd500;
        return q[9:0];
    endfunction

endpackage

// File: design/sasl_cfg.sv
// Configuration registers of the servo angle slew limiter, APB-style port.
// Keeps trim in pulse-offset form for the datapath. Depends on sasl_pkg.
module sasl_cfg
    import sasl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic signed [7:0] r_trim;
    logic [8:0]        r_step;
    logic [9:0]        r_interval;
    logic signed [9:0] r_trim_off;
    logic signed [7:0] n_trim_clamped;
    logic              wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb begin
        n_trim_clamped = $signed(pwdata[7:0]);
        if (n_trim_clamped < -8'sd90) begin
            n_trim_clamped = -8'sd90;
        end else if (n_trim_clamped > 8'sd90) begin
            n_trim_clamped = 8'sd90;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim     <= '0;
            r_trim_off <= '0;
            r_step     <= STEP_RESET;
            r_interval <= INTERVAL_RESET;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_TRIM: begin
                    r_trim     <= $signed(pwdata[7:0]);
                    r_trim_off <= deg_to_off(n_trim_clamped);
                end
                REG_STEP:     r_step     <= pwdata[8:0];
                REG_INTERVAL: r_interval <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TRIM:     prdata = DATA_W'(r_trim);
            REG_STEP:     prdata = DATA_W'(r_step);
            REG_INTERVAL: prdata = DATA_W'(r_interval);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.step_size = r_step;
    assign o_cfg.interval  = r_interval;
    assign o_cfg.trim_off  = r_trim_off;

endmodule

// File: design/sasl_core.sv
// Pulse state, slew step and result register of the servo angle slew limiter.
// Takes one registered word per cycle unless a result waits under output stall. Depends on sasl_pkg.
module sasl_core
    import sasl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_take,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_pulse_us,
    output logic        o_pulse_valid,
    output logic        o_pulse_written
);

    logic [11:0] r_cur;
    logic [11:0] r_tgt;
    logic        r_init;
    logic [9:0]  r_cnt;
    logic        r_out_valid;
    logic [11:0] r_out_pulse;
    logic        r_out_pvalid;
    logic        r_out_written;

    logic [11:0] n_cur;
    logic [11:0] n_tgt;
    logic        n_init;
    logic [9:0]  n_cnt;
    logic        n_written;

    logic              fire;
    logic signed [12:0] sum;
    logic [11:0]       tgt_cmd;
    logic [9:0]        cnt_inc;
    logic signed [12:0] d;
    logic signed [12:0] ad;
    logic signed [12:0] s;
    logic signed [12:0] st;

    assign o_take = !r_out_valid || !i_out_stall;
    assign fire   = i_valid && o_take;

    always_comb begin
        sum = PULSE_CENTER + 13'(i_item.angle_off) + 13'(i_cfg.trim_off);
        if (sum < PULSE_MIN) begin
            sum = PULSE_MIN;
        end else if (sum > PULSE_MAX) begin
            sum = PULSE_MAX;
        end
        tgt_cmd = sum[11:0];
    end

    always_comb begin
        cnt_inc = (r_cnt < CNT_MAX) ? r_cnt + 10'd1 : r_cnt;
        d  = $signed({1'b0, r_tgt}) - $signed({1'b0, r_cur});
        ad = (d < 0) ? -d : d;
        s  = $signed({4'b0, i_cfg.step_size});
        st = (ad < s) ? d : ((d > 0) ? s : -s);
    end

    always_comb begin
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_init    = r_init;
        n_cnt     = r_cnt;
        n_written = 1'b0;
        if (i_item.mode) begin
            n_tgt = tgt_cmd;
            if (!r_init) begin
                n_cur     = tgt_cmd;
                n_init    = 1'b1;
                n_written = 1'b1;
            end
        end else if (r_init) begin
            n_cnt = cnt_inc;
            if (cnt_inc >= i_cfg.interval) begin
                n_cnt = '0;
                if (r_cur != r_tgt) begin
                    n_cur     = 12'($signed({1'b0, r_cur}) + st);
                    n_written = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_tgt       <= '0;
            r_init      <= 1'b0;
            r_cnt       <= CNT_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_cur  <= n_cur;
                r_tgt  <= n_tgt;
                r_init <= n_init;
                r_cnt  <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pulse   <= n_cur;
            r_out_pvalid  <= n_init;
            r_out_written <= n_written;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pulse_us      = r_out_pulse;
    assign o_pulse_valid   = r_out_pvalid;
    assign o_pulse_written = r_out_written;

    a_written_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_written |-> r_out_pvalid)
        else $error("pulse write without valid pulse");

    a_init_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |=> r_init)
        else $error("initialized flag dropped");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (r_cur >= 12'd500 && r_cur <= 12'd2500))
        else $error("current pulse out of range");

    a_cur_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init |-> (r_cur == 12'd0 && r_cnt == CNT_MAX))
        else $error("state moved before first command");

endmodule

// File: design/servo_angle_slew_limiter.sv
// Top level of the servo angle slew limiter: input register, angle mapping,
// configuration port and pulse core. Depends on sasl_pkg, sasl_cfg, sasl_core.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_stall    i_mode, i_angle_deg
//  out      output     o_out_valid / i_out_stall  o_pulse_us, o_pulse_valid, o_pulse_written
//  cfg      input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One word per cycle unless the output stalls; path: input register, result register.
// The pulse state loop closes inside sasl_core.
// Synchronous active-low reset clears state; the interval counter starts saturated.
// While a result waits under output stall, take one more word, then stall the input.
module servo_angle_slew_limiter
    import sasl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic signed [8:0] i_angle_deg,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [11:0]       o_pulse_us,
    output logic              o_pulse_valid,
    output logic              o_pulse_written,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg  cfg;
    t_item r_item;
    t_item n_item;
    logic  r_in_valid;
    logic  take;
    logic  accept;

    logic signed [9:0] neg_angle;
    logic signed [7:0] angle_clamped;

    sasl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        neg_angle     = -10'(i_angle_deg);
        angle_clamped = neg_angle[7:0];
        if (neg_angle < -10'sd60) begin
            angle_clamped = -8'sd60;
        end else if (neg_angle > 10'sd60) begin
            angle_clamped = 8'sd60;
        end
        n_item.mode      = i_mode;
        n_item.angle_off = deg_to_off(angle_clamped);
    end

    assign o_in_stall = r_in_valid && !take;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    sasl_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (r_in_valid),
        .i_item          (r_item),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pulse_us      (o_pulse_us),
        .o_pulse_valid   (o_pulse_valid),
        .o_pulse_written (o_pulse_written)
    );

endmodule

// File: tb/sv/servo_pulse_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the servo angle slew limiter: follows register writes, predicts
// the pulse word for every accepted input word and compares it with the output.
// Depends on sasl_pkg for register codes, reset values and pulse limits.
module servo_pulse_checker
    import sasl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_mode,
    input  logic signed [8:0] i_angle_deg,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [11:0]       i_pulse_us,
    input  logic              i_pulse_valid,
    input  logic              i_pulse_written,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [11:0] pulse_us;
        logic        pulse_valid;
        logic        pulse_written;
    } t_pulse_word;

    t_pulse_word       expected_pulses[$];
    logic signed [7:0] trim_deg       = '0;
    logic [8:0]        step_us        = STEP_RESET;
    logic [9:0]        interval_ticks = INTERVAL_RESET;
    logic [11:0]       cur_pulse      = '0;
    logic [11:0]       tgt_pulse      = '0;
    logic              servo_live     = 1'b0;
    logic [9:0]        tick_count     = CNT_MAX;
    int                fails          = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int clamp_int(int x, int lo, int hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic int deg_offset(int d);
        return (d + 90) * 1000 / 180 - 500;
    endfunction

    function automatic t_pulse_word predict_pulse(logic mode, logic signed [8:0] angle);
        int          ang;
        int          p;
        int          d;
        int          mv;
        logic        wr;
        t_pulse_word w;
        wr = 1'b0;
        if (mode) begin
            ang = clamp_int(-int'(angle), -60, 60);
            p = int'(PULSE_CENTER) + deg_offset(ang)
                + deg_offset(clamp_int(int'(trim_deg), -90, 90));
            tgt_pulse = 12'(clamp_int(p, int'(PULSE_MIN), int'(PULSE_MAX)));
            if (!servo_live) begin
                cur_pulse  = tgt_pulse;
                servo_live = 1'b1;
                wr         = 1'b1;
            end
        end else if (servo_live) begin
            if (tick_count != CNT_MAX) tick_count++;
            if (tick_count >= interval_ticks) begin
                tick_count = '0;
                if (cur_pulse != tgt_pulse) begin
                    d  = int'(tgt_pulse) - int'(cur_pulse);
                    mv = (d < 0 ? -d : d) < int'(step_us) ? d
                         : (d > 0 ? int'(step_us) : -int'(step_us));
                    cur_pulse = 12'(int'(cur_pulse) + mv);
                    wr        = 1'b1;
                end
            end
        end
        w.pulse_us      = cur_pulse;
        w.pulse_valid   = servo_live;
        w.pulse_written = wr;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_pulse_word want;
        if (!i_rst_n) begin
            expected_pulses.delete();
            trim_deg       = '0;
            step_us        = STEP_RESET;
            interval_ticks = INTERVAL_RESET;
            cur_pulse      = '0;
            tgt_pulse      = '0;
            servo_live     = 1'b0;
            tick_count     = CNT_MAX;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_TRIM:     trim_deg       = pwdata[7:0];
                    REG_STEP:     step_us        = pwdata[8:0];
                    REG_INTERVAL: interval_ticks = pwdata[9:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pulses.size() == 0) begin
                    $error("unexpected pulse word: pulse_us %0d", i_pulse_us);
                    fails++;
                end else begin
                    want = expected_pulses.pop_front();
                    if (want.pulse_us !== i_pulse_us) begin
                        $error("pulse_us: expected %0d, actual %0d", want.pulse_us, i_pulse_us);
                        fails++;
                    end
                    if (want.pulse_valid !== i_pulse_valid) begin
                        $error("pulse_valid: expected %0d, actual %0d",
                               want.pulse_valid, i_pulse_valid);
                        fails++;
                    end
                    if (want.pulse_written !== i_pulse_written) begin
                        $error("pulse_written: expected %0d, actual %0d",
                               want.pulse_written, i_pulse_written);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_pulses.push_back(predict_pulse(i_mode, i_angle_deg));
        end
        o_fail_count <= fails;
        o_pending    <= expected_pulses.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the slew limiter testbench: clock, reset, register setup, input words
// and output stall; the verdict comes from servo_pulse_checker.
// Depends on sasl_pkg, servo_angle_slew_limiter and servo_pulse_checker.
module testbench;
    import sasl_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              mode      = 1'b0;
    logic signed [8:0] angle_deg = '0;
    logic              out_stall = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;

    logic              in_stall;
    logic              out_valid;
    logic [11:0]       pulse_us;
    logic              pulse_valid;
    logic              pulse_written;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    bit steady       = 1'b0;
    bit hold_off_req = 1'b0;

    servo_angle_slew_limiter DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_mode          (mode),
        .i_angle_deg     (angle_deg),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_pulse_us      (pulse_us),
        .o_pulse_valid   (pulse_valid),
        .o_pulse_written (pulse_written),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    servo_pulse_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_mode          (mode),
        .i_angle_deg     (angle_deg),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_pulse_us      (pulse_us),
        .i_pulse_valid   (pulse_valid),
        .i_pulse_written (pulse_written),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // hold off for a long stretch on request, else stall at random unless steady
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                for (int n = 0; n < 80; n++) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_stall <= !steady && ($urandom_range(99) < 34);
            end
        end
    end

    task automatic send_word(input logic m, input logic signed [8:0] ang);
        while (!steady && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        angle_deg <= ang;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int trim, input int step, input int interval);
        drain();
        write_reg(REG_TRIM, {24'd0, 8'(trim)});
        write_reg(REG_STEP, {23'd0, 9'(step)});
        write_reg(REG_INTERVAL, {22'd0, 10'(interval)});
    endtask

    initial begin
        logic signed [8:0] ang;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks before the first command do nothing
        send_word(1'b0, -9'sd256);
        send_word(1'b0, 9'sd255);
        send_word(1'b1, 9'sd0);
        send_word(1'b0, 9'sd0);
        send_word(1'b1, -9'sd256);
        send_word(1'b0, 9'sd17);
        send_word(1'b0, -9'sd17);
        send_word(1'b1, 9'sd255);
        send_word(1'b1, 9'sd60);
        send_word(1'b1, -9'sd60);
        send_word(1'b1, 9'sd61);
        send_word(1'b1, -9'sd61);
        send_word(1'b1, 9'sd1);
        send_word(1'b1, -9'sd1);
        // zero step and zero interval; trim above range
        set_config(127, 0, 0);
        send_word(1'b1, 9'sd0);
        send_word(1'b0, 9'sd0);
        send_word(1'b0, 9'sd0);
        // largest step, trim below range
        set_config(-128, 511, 1);
        send_word(1'b1, -9'sd256);
        send_word(1'b0, 9'sd0);
        send_word(1'b1, 9'sd255);
        send_word(1'b0, 9'sd0);
        send_word(1'b0, 9'sd0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(0, 10, 10);
                1: set_config(127, 511, 1023);
                2: set_config(-128, 1, 1);
                3: set_config(int'($urandom_range(255)) - 128, 0, 0);
                4: set_config(90, 500, 1000);
                5: set_config(-90, $urandom_range(40, 1), $urandom_range(5, 1));
                6: set_config(int'($urandom_range(255)) - 128, $urandom_range(511),
                              $urandom_range(15));
                default: set_config(int'($urandom_range(255)) - 128,
                                    $urandom_range(511, 1), 2);
            endcase
            steady = (ph == 4);
            for (int k = 0; k < 142; k++) begin
                if (ph == 2 && k == 40) begin
                    hold_off_req = 1'b1;
                    steady       = 1'b1;
                end
                if (ph == 2 && k == 70) steady = 1'b0;
                if ($urandom_range(99) < 12) begin
                    if ($urandom_range(3) == 0) ang = 9'($urandom);
                    else ang = 9'($urandom_range(140)) - 9'sd70;
                    send_word(1'b1, ang);
                end else begin
                    send_word(1'b0, 9'($urandom));
                end
            end
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: sim.f
design/sasl_pkg.sv
design/sasl_cfg.sv
design/sasl_core.sv
design/servo_angle_slew_limiter.sv
tb/sv/servo_pulse_checker.sv
tb/sv/testbench.sv
